// File: hdl/mcd_pkg.sv
// Shared constants, register codes and digit decode functions for the display clock.
package mcd_pkg;

    // Configuration port geometry
    localparam int CFG_WIDTH     = 10;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int NUM_TIMERS    = 4;

    // Default countdown width
    localparam int COUNT_WIDTH_DEF = 10;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_SCAN      = 2'd0,
        CFG_DOT       = 2'd1,
        CFG_HEARTBEAT = 2'd2,
        CFG_SECOND    = 2'd3
    } t_cfg_reg;

    // Period reset values, in register order
    localparam int SCAN_PERIOD_RST      = 25;
    localparam int DOT_PERIOD_RST       = 75;
    localparam int HEARTBEAT_PERIOD_RST = 50;
    localparam int SECOND_PERIOD_RST    = 100;

    // Field widths
    localparam int HOURS_WIDTH   = 5;
    localparam int MINUTES_WIDTH = 6;
    localparam int SECONDS_WIDTH = 6;
    localparam int DIGITS        = 4;
    localparam int SEG_WIDTH     = 7;

    // Time limits and reset time
    localparam int SECONDS_PER_MIN = 60;
    localparam int MINUTES_PER_HR  = 60;
    localparam int HOURS_PER_DAY   = 24;
    localparam int SECONDS_RST     = 50;
    localparam int MINUTES_RST     = 8;
    localparam int HOURS_RST       = 15;

    // Digit positions of HH:MM
    typedef enum logic [1:0] {
        DIG_HOURS_TENS = 2'd0,
        DIG_HOURS_UNIT = 2'd1,
        DIG_MINS_TENS  = 2'd2,
        DIG_MINS_UNIT  = 2'd3
    } t_digit;

    // Tens digit of a value below 60 by a compare chain
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd50) begin
            t = 4'd5;
        end else if (v >= 6'd40) begin
            t = 4'd4;
        end else if (v >= 6'd30) begin
            t = 4'd3;
        end else if (v >= 6'd20) begin
            t = 4'd2;
        end else if (v >= 6'd10) begin
            t = 4'd1;
        end else begin
            t = 4'd0;
        end
        return t;
    endfunction

    // Units digit: value minus ten times its tens digit
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [6:0] tx10;
        logic [5:0] u;
        tx10 = 7'(tens_of(v)) * 7'd10;
        u    = v - tx10[5:0];
        return u[3:0];
    endfunction

    // Active-low segment pattern, bit 0 = a .. bit 6 = g; non-digits light g only
    function automatic logic [SEG_WIDTH-1:0] seg_n_of(input logic [3:0] d);
        logic [SEG_WIDTH-1:0] on;
        case (d)
            4'd0:    on = 7'h3F;
            4'd1:    on = 7'h06;
            4'd2:    on = 7'h5B;
            4'd3:    on = 7'h4F;
            4'd4:    on = 7'h66;
            4'd5:    on = 7'h6D;
            4'd6:    on = 7'h7D;
            4'd7:    on = 7'h07;
            4'd8:    on = 7'h7F;
            4'd9:    on = 7'h6F;
            default: on = 7'h40;
        endcase
        return ~on;
    endfunction

endpackage

// File: hdl/mcd_tick_if.sv
// Valid/ready channel carrying one timebase tick per transfer.
interface mcd_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

// File: hdl/mcd_disp_if.sv
// Valid/ready channel carrying one display and time snapshot per transfer.
interface mcd_disp_if
    import mcd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [DIGITS-1:0]        digit_enable_n;
    logic [SEG_WIDTH-1:0]     segments_n;
    logic                     colon_dot;
    logic                     heartbeat_led;
    logic [HOURS_WIDTH-1:0]   hours_now;
    logic [MINUTES_WIDTH-1:0] minutes_now;
    logic [SECONDS_WIDTH-1:0] seconds_now;

    modport source (output valid, output digit_enable_n, output segments_n,
                    output colon_dot, output heartbeat_led, output hours_now,
                    output minutes_now, output seconds_now, input ready);
    modport sink   (input valid, input digit_enable_n, input segments_n,
                    input colon_dot, input heartbeat_led, input hours_now,
                    input minutes_now, input seconds_now, output ready);
endinterface

// File: hdl/multiplexed_clock_display.sv
// Top level: multiplexed seven-segment HH:MM clock driven by timebase ticks.
//
// Channels: i_tick takes one tick item per transfer (tick = 1 means one
// timebase period elapsed, 0 changes nothing). o_disp returns exactly one
// item per tick item: digit enables, segments, colon and heartbeat levels
// and the time after that tick.
// Configuration: i_cfg_wr_en with i_cfg_index / i_cfg_data writes one of
// four period registers (scan, dot, heartbeat, second) and reloads that
// countdown; write only while no tick result is pending.
// Latency: the result of a tick is valid the cycle after its transfer.
// Throughput: one tick per cycle while o_disp is ready; all state updates are
// registered together with the result at the tick transfer.
// Stall: a result waits in the output register; while it waits and o_disp
// is not ready, i_tick is held off. With o_disp ready, i_tick stays ready.
// Reset: time 15:08:50, periods 25/75/50/100, countdowns loaded, digit
// pointer at hours tens, pins and levels low, no result pending.
module multiplexed_clock_display
    import mcd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mcd_tick_if.sink                 i_tick,
    mcd_disp_if.source               o_disp,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data
);

    localparam int RST_VALS [NUM_TIMERS] = '{SCAN_PERIOD_RST, DOT_PERIOD_RST,
                                             HEARTBEAT_PERIOD_RST, SECOND_PERIOD_RST};

    logic                     in_xfer;
    logic                     step;
    logic [NUM_TIMERS-1:0]    fire;

    logic [HOURS_WIDTH-1:0]   r_hours, n_hours;
    logic [MINUTES_WIDTH-1:0] r_mins,  n_mins;
    logic [SECONDS_WIDTH-1:0] r_secs,  n_secs;
    logic [1:0]               r_digit, n_digit;
    logic                     r_dot,   n_dot;
    logic                     r_hb,    n_hb;
    logic [DIGITS-1:0]        r_en_n,  n_en_n;
    logic [SEG_WIDTH-1:0]     r_seg_n, n_seg_n;
    logic                     r_out_valid, n_out_valid;

    logic [3:0]               digit_val;
    logic [SECONDS_WIDTH:0]   secs_inc;
    logic [MINUTES_WIDTH:0]   mins_inc;
    logic [HOURS_WIDTH:0]     hours_inc;

    // Handshake: the output register frees the input side
    assign i_tick.ready = !r_out_valid || o_disp.ready;
    assign in_xfer      = i_tick.valid && i_tick.ready;
    assign step         = in_xfer && i_tick.tick;

    // Four countdowns, one per period register
    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_timer
        mcd_countdown #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .RESET_VAL   (RST_VALS[k])
        ) u_countdown (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (i_cfg_wr_en && (i_cfg_index == CFG_IDX_WIDTH'(k))),
            .i_load_val (i_cfg_data),
            .i_step     (step),
            .o_fire     (fire[k])
        );
    end

    // Digit shown at this scan step, from the time before the increment
    always_comb begin
        case (t_digit'(r_digit))
            DIG_HOURS_TENS: digit_val = tens_of(6'(r_hours));
            DIG_HOURS_UNIT: digit_val = units_of(6'(r_hours));
            DIG_MINS_TENS:  digit_val = tens_of(r_mins);
            DIG_MINS_UNIT:  digit_val = units_of(r_mins);
            default:        digit_val = 4'd0;
        endcase
    end

    // Next state for one tick
    always_comb begin
        n_hours   = r_hours;
        n_mins    = r_mins;
        n_secs    = r_secs;
        n_digit   = r_digit;
        n_dot     = r_dot;
        n_hb      = r_hb;
        n_en_n    = r_en_n;
        n_seg_n   = r_seg_n;
        secs_inc  = {1'b0, r_secs} + 7'd1;
        mins_inc  = {1'b0, r_mins};
        hours_inc = {1'b0, r_hours};

        if (step) begin
            // scan step
            if (fire[CFG_SCAN]) begin
                n_en_n  = ~(DIGITS'(1) << r_digit);
                n_seg_n = seg_n_of(digit_val);
                n_digit = r_digit + 2'd1;
            end
            // colon and heartbeat toggles
            if (fire[CFG_DOT]) begin
                n_dot = ~r_dot;
            end
            if (fire[CFG_HEARTBEAT]) begin
                n_hb = ~r_hb;
            end
            // one second with 60/60/24 wraparound
            if (fire[CFG_SECOND]) begin
                if (secs_inc >= 7'(SECONDS_PER_MIN)) begin
                    secs_inc = '0;
                    mins_inc = mins_inc + 7'd1;
                end
                if (mins_inc >= 7'(MINUTES_PER_HR)) begin
                    mins_inc  = '0;
                    hours_inc = hours_inc + 6'd1;
                end
                if (hours_inc >= 6'(HOURS_PER_DAY)) begin
                    hours_inc = '0;
                end
                n_secs  = secs_inc[SECONDS_WIDTH-1:0];
                n_mins  = mins_inc[MINUTES_WIDTH-1:0];
                n_hours = hours_inc[HOURS_WIDTH-1:0];
            end
        end
    end

    // Result pending flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_xfer) begin
            n_out_valid = 1'b1;
        end else if (o_disp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Clock state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours     <= HOURS_WIDTH'(HOURS_RST);
            r_mins      <= MINUTES_WIDTH'(MINUTES_RST);
            r_secs      <= SECONDS_WIDTH'(SECONDS_RST);
            r_digit     <= '0;
            r_dot       <= 1'b0;
            r_hb        <= 1'b0;
            r_en_n      <= '0;
            r_seg_n     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_xfer) begin
                r_hours <= n_hours;
                r_mins  <= n_mins;
                r_secs  <= n_secs;
                r_digit <= n_digit;
                r_dot   <= n_dot;
                r_hb    <= n_hb;
                r_en_n  <= n_en_n;
                r_seg_n <= n_seg_n;
            end
        end
    end

    // Result fields come straight from the registered state
    assign o_disp.valid          = r_out_valid;
    assign o_disp.digit_enable_n = r_en_n;
    assign o_disp.segments_n     = r_seg_n;
    assign o_disp.colon_dot      = r_dot;
    assign o_disp.heartbeat_led  = r_hb;
    assign o_disp.hours_now      = r_hours;
    assign o_disp.minutes_now    = r_mins;
    assign o_disp.seconds_now    = r_secs;

endmodule

// File: hdl/mcd_countdown.sv
// Reloading countdown with its period register; fires when it has run out.
module mcd_countdown
    import mcd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int RESET_VAL   = SCAN_PERIOD_RST
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [CFG_WIDTH-1:0] i_load_val,
    input  logic                 i_step,
    output logic                 o_fire
);

    logic [COUNT_WIDTH-1:0] r_period, n_period;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;

    // A count of one or zero has run out
    assign o_fire = (r_count <= COUNT_WIDTH'(1));

    // Load from the config port, else count down or reload on a tick
    always_comb begin
        n_period = r_period;
        n_count  = r_count;
        if (i_load) begin
            n_period = COUNT_WIDTH'(i_load_val);
            n_count  = COUNT_WIDTH'(i_load_val);
        end else if (i_step) begin
            n_count = o_fire ? r_period : r_count - COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= COUNT_WIDTH'(RESET_VAL);
            r_count  <= COUNT_WIDTH'(RESET_VAL);
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
        end
    end

endmodule
